FILE: src/psplat_pkg.sv
package psplat_pkg;

   // grid geometry and storage
   localparam int MAX_WIDTH    = 128;
   localparam int MAX_HEIGHT   = 128;
   localparam int DENSITY_BITS = 32;
   localparam int GRID_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W       = $clog2(GRID_DEPTH);
   localparam int COORD_W      = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
   localparam int DIM_W        = COORD_W + 1;
   localparam int ROW_W        = COORD_W + DIM_W;

   // field and register widths
   localparam int OPCODE_W   = 2;
   localparam int POS_W      = 24;
   localparam int IDX_W      = 14;
   localparam int DENS_OUT_W = 32;
   localparam int DIMCFG_W   = 8;
   localparam int CS_W       = 16;
   localparam int INV_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // fixed point of the coordinate path
   localparam int COORDV_W = POS_W + 1;
   localparam int PROD_W   = COORDV_W + INV_W;
   localparam int CELL_LSB = 25;
   localparam int CELL_W   = PROD_W - CELL_LSB;
   localparam int FRAC_W   = 8;
   localparam int FRAC_LSB = CELL_LSB - FRAC_W;
   localparam int SHARE_W  = FRAC_W + 1;
   localparam int WEIGHT_W = 2 * FRAC_W + 1;
   localparam logic [SHARE_W-1:0] ONE_SHARE = SHARE_W'(1 << FRAC_W);

   // splat sequencing
   localparam int CORNERS     = 4;
   localparam int CORNER_W    = $clog2(CORNERS);
   localparam int SETUP_LAST  = 3;

   // register reset values
   localparam logic [DIMCFG_W-1:0] GRID_WIDTH_RST  = DIMCFG_W'(64);
   localparam logic [DIMCFG_W-1:0] GRID_HEIGHT_RST = DIMCFG_W'(64);
   localparam logic [CS_W-1:0]     SPACING_RST     = CS_W'(256);
   localparam logic [INV_W-1:0]    INV_SPACING_RST = INV_W'(65536);

   typedef logic [DENSITY_BITS-1:0] density_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SPLAT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_SPACING     = 2'd2,
      CSR_INV_SPACING = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SPLAT,
      ST_DRAIN,
      ST_READ,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] c0;
      logic [COORD_W-1:0] c1;
      logic [SHARE_W-1:0] share;
   } axis_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      density_type        wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } ram_req_type;

   // grid dimension forced into 2..maxv
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMCFG_W-1:0] v,
                                                  input int maxv);
      logic [DIM_W-1:0] r;
      if (32'(v) < 32'd2) r = DIM_W'(2);
      else if (32'(v) > 32'(maxv)) r = DIM_W'(maxv);
      else r = DIM_W'(v);
      return r;
   endfunction

   // accumulator shown on the 32 bit density field, capped at all ones
   function automatic logic [DENS_OUT_W-1:0] cap_density(input density_type d);
      logic [63:0] wide;
      logic [DENS_OUT_W-1:0] r;
      wide = 64'(d);
      if (wide > 64'hFFFF_FFFF) r = '1;
      else r = wide[DENS_OUT_W-1:0];
      return r;
   endfunction

endpackage

FILE: src/psplat_ram.sv
module psplat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/psplat_axis.sv
module psplat_axis import psplat_pkg::*; (
   input  logic               clock,
   input  logic [POS_W-1:0]   pos,
   input  logic [CS_W-1:0]    spacing,
   input  logic [INV_W-1:0]   inv_spacing,
   input  logic [COORD_W-1:0] limit,
   output axis_type           axis
);

   logic [COORDV_W-1:0] two_pos;
   logic [COORDV_W-1:0] coord_in, coord_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;
   logic [CELL_W-1:0]   cell_num;
   axis_type            axis_in, axis_ff;

   // shift down by half a cell, clamped at zero
   always_comb begin
      two_pos = {pos, 1'b0};
      if (two_pos > COORDV_W'(spacing)) coord_in = two_pos - COORDV_W'(spacing);
      else coord_in = '0;
   end

   // scale to cell units
   assign prod_in = PROD_W'(coord_ff) * PROD_W'(inv_spacing);

   // base cell, far cell and share with clamping at the grid edge
   always_comb begin
      cell_num = prod_ff[PROD_W-1:CELL_LSB];
      if (cell_num > CELL_W'(limit)) begin
         axis_in.c0    = limit;
         axis_in.share = ONE_SHARE;
      end else begin
         axis_in.c0    = COORD_W'(cell_num);
         axis_in.share = {1'b0, prod_ff[FRAC_LSB +: FRAC_W]};
      end
      if (axis_in.c0 == limit) axis_in.c1 = limit;
      else axis_in.c1 = COORD_W'(axis_in.c0 + 1'b1);
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
      prod_ff  <= prod_in;
      axis_ff  <= axis_in;
   end

   assign axis = axis_ff;

endmodule

FILE: src/psplat_ctrl.sv
module psplat_ctrl import psplat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [IDX_W-1:0]      req_cell_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DENS_OUT_W-1:0] rsp_density,
   output logic [IDX_W-1:0]      rsp_read_index,
   input  logic [DIM_W-1:0]      width_c,
   output logic [POS_W-1:0]      pos_x,
   output logic [POS_W-1:0]      pos_y,
   input  axis_type              axis_x,
   input  axis_type              axis_y,
   output ram_req_type           ram_req,
   input  density_type           ram_rd_data
);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [IDX_W-1:0]  rd_index_ff, rd_index_in;
   logic              rd_zero_ff, rd_zero_in;
   logic [ADDR_W-1:0]   corner_addr_ff [CORNERS];
   logic [ADDR_W-1:0]   corner_addr_in [CORNERS];
   logic [WEIGHT_W-1:0] corner_w_ff [CORNERS];
   logic [WEIGHT_W-1:0] corner_w_in [CORNERS];
   logic                acc_pend_ff, acc_pend_in;
   logic [ADDR_W-1:0]   acc_addr_ff, acc_addr_in;
   logic [WEIGHT_W-1:0] acc_w_ff, acc_w_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]   fwd_addr_ff, fwd_addr_in;
   density_type         fwd_data_ff, fwd_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DENS_OUT_W-1:0] rsp_density_ff, rsp_density_in;
   logic [IDX_W-1:0]      rsp_read_index_ff, rsp_read_index_in;

   logic                  req_accept;
   opcode_type            opcode;
   logic                  rsp_free;
   logic                  setup_done;
   logic [CORNER_W-1:0]   corner_sel;
   logic                  corner_last;
   logic                  clear_last;
   logic [SHARE_W-1:0]    rx, ry;
   logic [ROW_W-1:0]      row0, row1;
   density_type           acc_cur;
   logic [DENSITY_BITS:0] acc_sum;
   density_type           acc_new;
   logic                  rsp_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign opcode     = opcode_type'(req_opcode);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign setup_done = (cnt_ff == ADDR_W'(SETUP_LAST));
   assign corner_sel = cnt_ff[CORNER_W-1:0];
   assign corner_last = (corner_sel == CORNER_W'(CORNERS - 1));
   assign clear_last = (cnt_ff == ADDR_W'(GRID_DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (opcode)
                  OP_SPLAT: state_in = ST_SETUP;
                  OP_READ:  state_in = ST_READ;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: if (setup_done) state_in = ST_SPLAT;
         ST_SPLAT: if (corner_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_IDLE;
         ST_READ:  if (rsp_free) state_in = ST_IDLE;
         ST_CLEAR: if (clear_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // corner weights and addresses from both axes
   always_comb begin
      rx   = ONE_SHARE - axis_x.share;
      ry   = ONE_SHARE - axis_y.share;
      row0 = ROW_W'(axis_y.c0) * ROW_W'(width_c);
      row1 = ROW_W'(axis_y.c1) * ROW_W'(width_c);
   end

   // read-modify-write with forwarding of the write just made
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == acc_addr_ff)) acc_cur = fwd_data_ff;
      else acc_cur = ram_rd_data;
      acc_sum = (DENSITY_BITS + 1)'(acc_cur) + (DENSITY_BITS + 1)'(acc_w_ff);
      if (acc_sum[DENSITY_BITS]) acc_new = '1;
      else acc_new = acc_sum[DENSITY_BITS-1:0];
   end

   // outputs and datapath control
   always_comb begin
      cnt_in      = '0;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      rd_index_in = rd_index_ff;
      rd_zero_in  = rd_zero_ff;
      for (int i = 0; i < CORNERS; i++) begin
         corner_addr_in[i] = corner_addr_ff[i];
         corner_w_in[i]    = corner_w_ff[i];
      end
      acc_pend_in  = 1'b0;
      acc_addr_in  = acc_addr_ff;
      acc_w_in     = acc_w_ff;
      fwd_valid_in = 1'b0;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_load     = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = acc_addr_ff;
      ram_req.wr_data = acc_new;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = ADDR_W'(req_cell_index);

      // request capture
      if (req_accept) begin
         pos_x_in    = req_pos_x;
         pos_y_in    = req_pos_y;
         rd_index_in = req_cell_index;
         rd_zero_in  = (32'(req_cell_index) >= 32'(GRID_DEPTH));
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (opcode == OP_READ)) begin
               ram_req.rd_en = 1'b1;
            end
         end
         ST_SETUP: begin
            if (setup_done) begin
               corner_w_in[0] = WEIGHT_W'(rx) * WEIGHT_W'(ry);
               corner_w_in[1] = WEIGHT_W'(axis_x.share) * WEIGHT_W'(ry);
               corner_w_in[2] = WEIGHT_W'(axis_x.share) * WEIGHT_W'(axis_y.share);
               corner_w_in[3] = WEIGHT_W'(rx) * WEIGHT_W'(axis_y.share);
               corner_addr_in[0] = ADDR_W'(row0 + ROW_W'(axis_x.c0));
               corner_addr_in[1] = ADDR_W'(row0 + ROW_W'(axis_x.c1));
               corner_addr_in[2] = ADDR_W'(row1 + ROW_W'(axis_x.c1));
               corner_addr_in[3] = ADDR_W'(row1 + ROW_W'(axis_x.c0));
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SPLAT: begin
            cnt_in          = cnt_ff + 1'b1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = corner_addr_ff[corner_sel];
            acc_pend_in     = 1'b1;
            acc_addr_in     = corner_addr_ff[corner_sel];
            acc_w_in        = corner_w_ff[corner_sel];
         end
         ST_READ: begin
            rsp_load = rsp_free;
         end
         ST_CLEAR: begin
            cnt_in          = cnt_ff + 1'b1;
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff;
            ram_req.wr_data = '0;
         end
         default: begin
         end
      endcase

      // write-back of the corner read in the previous cycle
      if (acc_pend_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = acc_addr_ff;
         ram_req.wr_data = acc_new;
         fwd_valid_in    = 1'b1;
         fwd_addr_in     = acc_addr_ff;
         fwd_data_in     = acc_new;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_density_in    = rsp_density_ff;
      rsp_read_index_in = rsp_read_index_ff;
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_density_in    = rd_zero_ff ? '0 : cap_density(ram_rd_data);
         rsp_read_index_in = rd_index_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         acc_pend_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_pend_ff  <= acc_pend_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      rd_index_ff <= rd_index_in;
      rd_zero_ff  <= rd_zero_in;
      for (int i = 0; i < CORNERS; i++) begin
         corner_addr_ff[i] <= corner_addr_in[i];
         corner_w_ff[i]    <= corner_w_in[i];
      end
      acc_addr_ff       <= acc_addr_in;
      acc_w_ff          <= acc_w_in;
      fwd_addr_ff       <= fwd_addr_in;
      fwd_data_ff       <= fwd_data_in;
      rsp_density_ff    <= rsp_density_in;
      rsp_read_index_ff <= rsp_read_index_in;
   end

   assign pos_x          = pos_x_ff;
   assign pos_y          = pos_y_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_density    = rsp_density_ff;
   assign rsp_read_index = rsp_read_index_ff;

endmodule

FILE: src/particle_density_splat_top.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_opcode, req_pos_x, req_pos_y, req_cell_index
// rsp       out        rsp_valid/rsp_stall   rsp_density, rsp_read_index
// csr       in         csr_write_enable      csr_index, csr_wdata
//
// a splat runs through the coordinate pipeline (offset, scale multiply, clamp,
// weights), then one grid memory read-modify-write per corner, one per cycle,
// and a final write-back; the next request is taken only after that write-back.
// a read is one memory read; a clear writes zero to every cell of the grid.
// after reset the grid is swept to zero, all GRID_DEPTH (16384) cells, with
// req_stall high; a read waits in the block while an earlier result is stalled.
module particle_density_splat_top import psplat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [IDX_W-1:0]      req_cell_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DENS_OUT_W-1:0] rsp_density,
   output logic [IDX_W-1:0]      rsp_read_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DIMCFG_W-1:0] grid_width_ff, grid_width_in;
   logic [DIMCFG_W-1:0] grid_height_ff, grid_height_in;
   logic [CS_W-1:0]     spacing_ff, spacing_in;
   logic [INV_W-1:0]    inv_spacing_ff, inv_spacing_in;

   logic [DIM_W-1:0]   width_c, height_c;
   logic [COORD_W-1:0] limit_x, limit_y;
   logic [POS_W-1:0]   pos_x, pos_y;
   axis_type           axis_x, axis_y;
   ram_req_type        ram_req;
   density_type        ram_rd_data;

   // configuration registers
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      spacing_in     = spacing_ff;
      inv_spacing_in = inv_spacing_ff;
      if (csr_write_enable) begin
         case (csr_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[DIMCFG_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata[DIMCFG_W-1:0];
            CSR_SPACING:     spacing_in     = csr_wdata[CS_W-1:0];
            CSR_INV_SPACING: inv_spacing_in = csr_wdata[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         spacing_ff     <= SPACING_RST;
         inv_spacing_ff <= INV_SPACING_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         spacing_ff     <= spacing_in;
         inv_spacing_ff <= inv_spacing_in;
      end
   end

   // grid size in use and last cell on each axis
   always_comb begin
      width_c  = clamp_dim(grid_width_ff, MAX_WIDTH);
      height_c = clamp_dim(grid_height_ff, MAX_HEIGHT);
      limit_x  = COORD_W'(width_c - 1'b1);
      limit_y  = COORD_W'(height_c - 1'b1);
   end

   psplat_axis u_axis_x (
      .clock       (clock),
      .pos         (pos_x),
      .spacing     (spacing_ff),
      .inv_spacing (inv_spacing_ff),
      .limit       (limit_x),
      .axis        (axis_x)
   );

   psplat_axis u_axis_y (
      .clock       (clock),
      .pos         (pos_y),
      .spacing     (spacing_ff),
      .inv_spacing (inv_spacing_ff),
      .limit       (limit_y),
      .axis        (axis_y)
   );

   psplat_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_density    (rsp_density),
      .rsp_read_index (rsp_read_index),
      .width_c        (width_c),
      .pos_x          (pos_x),
      .pos_y          (pos_y),
      .axis_x         (axis_x),
      .axis_y         (axis_y),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data)
   );

   // density grid
   psplat_ram #(
      .WIDTH (DENSITY_BITS),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   // reset starts the clearing sweep, so no request is taken
   a_reset_clears: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken straight after reset");

   // any real operation keeps the block busy once it has been accepted
   a_op_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_opcode == OP_SPLAT || req_opcode == OP_READ ||
       req_opcode == OP_CLEAR)) |=> req_stall)
      else $error("block idle right after accepting an operation");

   // the grid is only written while the block is busy
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> req_stall)
      else $error("grid write while idle");
`endif

endmodule

FILE: tb/splat_density_checker.sv
module splat_density_checker import psplat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [IDX_W-1:0]      req_cell_index,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DENS_OUT_W-1:0] rsp_density,
   input  logic [IDX_W-1:0]      rsp_read_index,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    reads_due
);

   typedef struct packed {
      logic [DENS_OUT_W-1:0] density;
      logic [IDX_W-1:0]      read_index;
   } cell_read_type;

   // shadow of the accumulator store and of the registers
   density_type         grid_shadow [GRID_DEPTH];
   cell_read_type       cell_reads_due [$];
   logic [DIMCFG_W-1:0] width_reg;
   logic [DIMCFG_W-1:0] height_reg;
   logic [CS_W-1:0]     spacing_reg;
   logic [INV_W-1:0]    inv_cell_reg;
   int                  mismatches = 0;

   // grid size actually in use
   function automatic logic [DIM_W-1:0] dim_in_use(input logic [DIMCFG_W-1:0] v, input int most);
      logic [DIM_W-1:0] d;
      d = (v < 2) ? DIM_W'(2) : ((int'(v) > most) ? DIM_W'(most) : DIM_W'(v));
      return d;
   endfunction

   // base cell, far cell and share along one axis
   function automatic axis_type place_axis(input logic [POS_W-1:0] pos,
                                           input logic [DIM_W-1:0] dim);
      logic [POS_W:0]     doubled;
      logic [POS_W:0]     shifted;
      logic [PROD_W-1:0]  scaled;
      logic [CELL_W-1:0]  whole;
      logic [COORD_W-1:0] last;
      axis_type           a;
      doubled = {pos, 1'b0};
      shifted = (doubled > (POS_W+1)'(spacing_reg)) ?
                doubled - (POS_W+1)'(spacing_reg) : '0;
      scaled  = PROD_W'(shifted) * PROD_W'(inv_cell_reg);
      whole   = scaled[PROD_W-1:CELL_LSB];
      last    = COORD_W'(dim - 1'b1);
      if (whole > CELL_W'(last)) begin
         // past the grid: pinned to the last cell with a full share
         a.c0    = last;
         a.share = ONE_SHARE;
      end else begin
         a.c0    = COORD_W'(whole);
         a.share = SHARE_W'(scaled[CELL_LSB-1:FRAC_LSB]);
      end
      a.c1 = (a.c0 == last) ? last : a.c0 + 1'b1;
      return a;
   endfunction

   // saturating add of one corner weight
   task automatic add_weight(input int idx, input logic [WEIGHT_W-1:0] w);
      logic [DENSITY_BITS:0] sum;
      sum = {1'b0, grid_shadow[idx]} + (DENSITY_BITS+1)'(w);
      grid_shadow[idx] = sum[DENSITY_BITS] ? '1 : sum[DENSITY_BITS-1:0];
   endtask

   // bilinear deposit of one particle
   task automatic deposit_particle(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      axis_type           ax;
      axis_type           ay;
      logic [SHARE_W-1:0] rx;
      logic [SHARE_W-1:0] ry;
      int                 row0;
      int                 row1;
      w    = dim_in_use(width_reg, MAX_WIDTH);
      h    = dim_in_use(height_reg, MAX_HEIGHT);
      ax   = place_axis(x, w);
      ay   = place_axis(y, h);
      rx   = ONE_SHARE - ax.share;
      ry   = ONE_SHARE - ay.share;
      row0 = int'(ay.c0) * int'(w);
      row1 = int'(ay.c1) * int'(w);
      add_weight(row0 + int'(ax.c0), WEIGHT_W'(rx) * WEIGHT_W'(ry));
      add_weight(row0 + int'(ax.c1), WEIGHT_W'(ax.share) * WEIGHT_W'(ry));
      add_weight(row1 + int'(ax.c1), WEIGHT_W'(ax.share) * WEIGHT_W'(ay.share));
      add_weight(row1 + int'(ax.c0), WEIGHT_W'(rx) * WEIGHT_W'(ay.share));
   endtask

   always @(posedge clock) begin
      cell_read_type got;
      cell_read_type want;
      logic [63:0]   wide;
      if (reset) begin
         width_reg    = GRID_WIDTH_RST;
         height_reg   = GRID_HEIGHT_RST;
         spacing_reg  = SPACING_RST;
         inv_cell_reg = INV_SPACING_RST;
         foreach (grid_shadow[i]) grid_shadow[i] = '0;
         cell_reads_due.delete();
      end else begin
         // results first: a result on this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_density, rsp_read_index};
            if (cell_reads_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got density %h index %0d",
                        $time, got.density, got.read_index);
            end else begin
               want = cell_reads_due.pop_front();
               if (got.density !== want.density) begin
                  mismatches++;
                  $display("%0t: density of cell %0d expected %h got %h",
                           $time, want.read_index, want.density, got.density);
               end
               if (got.read_index !== want.read_index) begin
                  mismatches++;
                  $display("%0t: read index expected %0d got %0d",
                           $time, want.read_index, got.read_index);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_SPLAT: begin
                  deposit_particle(req_pos_x, req_pos_y);
               end
               OP_READ: begin
                  wide = 64'(grid_shadow[req_cell_index]);
                  want.density    = (wide > 64'hFFFF_FFFF) ? '1 : wide[DENS_OUT_W-1:0];
                  want.read_index = req_cell_index;
                  cell_reads_due.push_back(want);
               end
               OP_CLEAR: begin
                  foreach (grid_shadow[i]) grid_shadow[i] = '0;
               end
               default: begin
                  // unused opcode leaves everything alone
               end
            endcase
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRID_WIDTH:  width_reg    = csr_wdata[DIMCFG_W-1:0];
               CSR_GRID_HEIGHT: height_reg   = csr_wdata[DIMCFG_W-1:0];
               CSR_SPACING:     spacing_reg  = csr_wdata[CS_W-1:0];
               CSR_INV_SPACING: inv_cell_reg = csr_wdata[INV_W-1:0];
               default: ;
            endcase
         end
      end
      reads_due   <= cell_reads_due.size();
      error_count <= mismatches;
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import psplat_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   // a clear or the sweep after reset holds off requests for a whole grid pass
   localparam int QUIET_LIMIT   = 4 * (GRID_DEPTH + 1) + 2000;
   localparam int SETTLE_CYCLES = 20;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = OP_SPLAT;
   logic [POS_W-1:0]      req_pos_x = '0;
   logic [POS_W-1:0]      req_pos_y = '0;
   logic [IDX_W-1:0]      req_cell_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DENS_OUT_W-1:0] rsp_density;
   logic [IDX_W-1:0]      rsp_read_index;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GRID_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    error_count;
   int                    reads_due;
   int                    sender_idle_pct = 0;
   int                    receiver_stall_pct = 0;
   int                    quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   particle_density_splat_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_density      (rsp_density),
      .rsp_read_index   (rsp_read_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   splat_density_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_density      (rsp_density),
      .rsp_read_index   (rsp_read_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .reads_due        (reads_due)
   );

   // random back-pressure on results
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int dim_span(input int v, input int most);
      int d;
      d = v & 8'hFF;
      d = (d < 2) ? 2 : ((d > most) ? most : d);
      return d;
   endfunction

   // one request, with random sender gaps in front of it
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic splat_at(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      send_request(OP_SPLAT, x, y, IDX_W'($urandom));
   endtask

   task automatic read_cell(input int idx);
      send_request(OP_READ, POS_W'($urandom), POS_W'($urandom), IDX_W'(idx));
   endtask

   // stop sending until every read has come back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (reads_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all four registers, junk in the unused upper bits
   task automatic configure(input int w, input int h, input int cs, input int inv);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_GRID_WIDTH;
      csr_wdata        <= {16'($urandom), 8'(w)};
      @(negedge clock);
      csr_index        <= CSR_GRID_HEIGHT;
      csr_wdata        <= {16'($urandom), 8'(h)};
      @(negedge clock);
      csr_index        <= CSR_SPACING;
      csr_wdata        <= {8'($urandom), 16'(cs)};
      @(negedge clock);
      csr_index        <= CSR_INV_SPACING;
      csr_wdata        <= 24'(inv);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
         IDLE_SENDER:   begin sender_idle_pct <= 60; receiver_stall_pct <= 0;  end
         IDLE_RECEIVER: begin sender_idle_pct <= 0;  receiver_stall_pct <= 60; end
         default:       begin sender_idle_pct <= 35; receiver_stall_pct <= 35; end
      endcase
   endtask

   // mostly particles inside the grid, some anywhere; mostly reads of used cells
   task automatic random_request(input int wu, input int hu, input int cs);
      int roll;
      int reach_x;
      int reach_y;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      roll    = $urandom_range(999);
      reach_x = wu * cs + cs;
      reach_y = hu * cs + cs;
      reach_x = (reach_x > 24'hFFFFFF) ? 24'hFFFFFF : reach_x;
      reach_y = (reach_y > 24'hFFFFFF) ? 24'hFFFFFF : reach_y;
      if (roll < 4) begin
         send_request(OP_CLEAR, POS_W'($urandom), POS_W'($urandom), IDX_W'($urandom));
      end else if (roll < 10) begin
         send_request(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), IDX_W'($urandom));
      end else if (roll < 620) begin
         x = ($urandom_range(99) < 85) ? POS_W'($urandom_range(reach_x)) : POS_W'($urandom);
         y = ($urandom_range(99) < 85) ? POS_W'($urandom_range(reach_y)) : POS_W'($urandom);
         splat_at(x, y);
      end else if (roll < 930) begin
         read_cell($urandom_range(wu * hu - 1));
      end else begin
         read_cell($urandom_range(GRID_DEPTH - 1));
      end
   endtask

   task automatic run_phase(input idle_mode_type mode, input int w, input int h,
                            input int cs, input int inv, input int count);
      int wu;
      int hu;
      set_idling(mode);
      configure(w, h, cs, inv);
      wu = dim_span(w, MAX_WIDTH);
      hu = dim_span(h, MAX_HEIGHT);
      repeat (count) random_request(wu, hu, cs);
      // closing read so that the block is known to be idle afterwards
      read_cell($urandom_range(wu * hu - 1));
      settle();
   endtask

   initial begin
      int cs;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed checks on the reset geometry: 64 x 64 cells of 1.0
      set_idling(IDLE_NONE);
      configure(64, 64, 256, 65536);
      send_request(OP_CLEAR, '0, '0, '0);
      splat_at('0, '0);
      splat_at(24'd127, 24'd50);
      splat_at(24'(5 * 256 + 128), 24'(7 * 256 + 192));
      splat_at('1, '1);
      splat_at('1, 24'(3 * 256 + 200));
      splat_at(24'(63 * 256 + 128), 24'(62 * 256 + 128 + 255));
      read_cell(0);
      read_cell(1);
      read_cell(64);
      read_cell(5 + 7 * 64);
      read_cell(6 + 8 * 64);
      read_cell(63 + 3 * 64);
      read_cell(63 + 62 * 64);
      read_cell(4095);
      send_request(OP_UNUSED, '1, '1, '1);
      read_cell(0);
      read_cell(4096);
      read_cell(GRID_DEPTH - 1);
      send_request(OP_CLEAR, '1, '1, '1);
      read_cell(0);
      read_cell(4095);
      settle();

      run_phase(IDLE_SENDER,   64,  64,  256,   65536,    250);
      run_phase(IDLE_RECEIVER, 4,   4,   512,   32768,    250);
      run_phase(IDLE_BOTH,     2,   2,   1,     24'hFFFFFF, 150);
      run_phase(IDLE_NONE,     128, 128, 16'hFFFF, 1,     150);
      // zero reciprocal, and grid sizes outside the usable range
      run_phase(IDLE_SENDER,   0,   255, 256,   0,        100);
      run_phase(IDLE_RECEIVER, 1,   200, 64,    262144,   200);
      cs = $urandom_range(1024, 32);
      run_phase(IDLE_BOTH, $urandom_range(16, 2), $urandom_range(16, 2), cs,
                (1 << 24) / cs, 250);
      cs = $urandom_range(2048, 16);
      run_phase(IDLE_NONE, $urandom_range(128, 2), $urandom_range(128, 2), cs,
                (1 << 24) / cs, 200);

      // pile-up on one cell: every splat lands whole on the far corner
      set_idling(IDLE_NONE);
      configure(2, 2, 256, 65536);
      send_request(OP_CLEAR, '0, '0, '0);
      repeat (40) splat_at('1, '1);
      read_cell(3);
      splat_at('1, '1);
      splat_at('1, '1);
      read_cell(3);
      read_cell(0);
      settle();

      if (error_count == 0 && reads_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/psplat_pkg.sv
src/psplat_ram.sv
src/psplat_axis.sv
src/psplat_ctrl.sv
src/particle_density_splat_top.sv
tb/splat_density_checker.sv
tb/tb_top.sv
